// ----- hdl/wbi_pkg.sv -----
// ----------------------------------------------------------------------------
// wbi_pkg
// Shared types and constants for the width bucket histogram binner.
// ----------------------------------------------------------------------------
package wbi_pkg;

  localparam int ValueWidthDef = 64;
  localparam int IndexWidthDef = 31;
  localparam int CountW        = 31;   // width of the bucket count register
  localparam int CfgIdxW       = 2;

  localparam logic [CfgIdxW-1:0] REG_FIRST_BOUND  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_BOUND = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BUCKET_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_EQ_BOUNDS = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  // how the index of an item is formed at the end of the pipe
  typedef enum logic [1:0] {
    CLS_DIV   = 2'd0,
    CLS_UNDER = 2'd1,
    CLS_OVER  = 2'd2,
    CLS_ERR   = 2'd3
  } cls_t;

endpackage

// ----- hdl/width_bucket_integer.sv -----
// ----------------------------------------------------------------------------
// width_bucket_integer
// Equal-width histogram binning of signed values against configured bounds.
// ----------------------------------------------------------------------------
// One sample enters and one result leaves per clock while the output is not
// stalled. The stages are: input register, classify, a split multiply of
// count by the distance, the product add, then one restoring division step
// per quotient bit (31 stages, each a VALUE_WIDTH+1 bit compare and
// subtract), and the output register. The whole pipe advances together; a
// stalled output holds every stage. Bounds and count are read live, so write
// them only while the pipe is empty.
module width_bucket_integer #(
  parameter int VALUE_WIDTH = wbi_pkg::ValueWidthDef,
  parameter int INDEX_WIDTH = wbi_pkg::IndexWidthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // [63:0] sample_value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // [30:0] bucket_index, [32:31] status
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wbi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);
  import wbi_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int DL = VW / 2;
  localparam int DH = VW - DL;
  localparam int NW = CountW + VW;
  localparam logic [CountW:0] MaxIdx = {{(CountW + 1 - INDEX_WIDTH){1'b0}},
                                        {INDEX_WIDTH{1'b1}}};

  typedef struct packed {
    logic            vld;
    cls_t            cls;
    status_t         st;
    logic [CountW-1:0] c;
    logic [VW-1:0]   w;
    logic [VW-1:0]   rem;
    logic [CountW-1:0] nlow;
    logic [CountW-1:0] q;
  } div_t;

  // configuration
  logic signed [63:0] b1_r, b2_r;
  logic [CountW-1:0]  cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r  <= 64'sd0;
      b2_r  <= 64'sd100;
      cnt_r <= CountW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_BOUND:  b1_r  <= cfg_data;
        REG_SECOND_BOUND: b2_r  <= cfg_data;
        REG_BUCKET_COUNT: cnt_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: input register
  logic              s1_vld_r;
  logic signed [VW-1:0] s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_tvalid;
  end
  always_ff @(posedge clk) if (adv) s1_v_r <= in_tdata[VW-1:0];

  // stage 2: classify and form distance and width
  logic signed [VW-1:0] b1, b2;
  assign b1 = b1_r[VW-1:0];
  assign b2 = b2_r[VW-1:0];

  logic              s2_vld_r;
  cls_t              s2_cls_r, s2_cls_nxt;
  status_t           s2_st_r, s2_st_nxt;
  logic [VW-1:0]     s2_d_r, s2_d_nxt, s2_w_r, s2_w_nxt;

  always_comb begin
    s2_cls_nxt = CLS_DIV;
    s2_st_nxt  = ST_OK;
    s2_d_nxt   = VW'(s1_v_r - b1);
    s2_w_nxt   = VW'(b2 - b1);
    priority if (cnt_r == '0) begin
      s2_cls_nxt = CLS_ERR;
      s2_st_nxt  = ST_BAD_COUNT;
    end else if (b1 == b2) begin
      s2_cls_nxt = CLS_ERR;
      s2_st_nxt  = ST_EQ_BOUNDS;
    end else if (b1 < b2) begin
      if (s1_v_r < b1)       s2_cls_nxt = CLS_UNDER;
      else if (s1_v_r >= b2) s2_cls_nxt = CLS_OVER;
    end else begin
      s2_d_nxt = VW'(b1 - s1_v_r);
      s2_w_nxt = VW'(b1 - b2);
      if (s1_v_r > b1)       s2_cls_nxt = CLS_UNDER;
      else if (s1_v_r <= b2) s2_cls_nxt = CLS_OVER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cls_r <= s2_cls_nxt;
      s2_st_r  <= s2_st_nxt;
      s2_d_r   <= s2_d_nxt;
      s2_w_r   <= s2_w_nxt;
    end
  end

  // stage 3: two partial products of count by distance
  logic              s3_vld_r;
  cls_t              s3_cls_r;
  status_t           s3_st_r;
  logic [VW-1:0]     s3_w_r;
  logic [CountW+DL-1:0] s3_plo_r;
  logic [CountW+DH-1:0] s3_phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cls_r <= s2_cls_r;
      s3_st_r  <= s2_st_r;
      s3_w_r   <= s2_w_r;
      s3_plo_r <= (CountW+DL)'(cnt_r) * (CountW+DL)'(s2_d_r[DL-1:0]);
      s3_phi_r <= (CountW+DH)'(cnt_r) * (CountW+DH)'(s2_d_r[VW-1:DL]);
    end
  end

  // stage 4: product sum, start of the long division
  logic [NW-1:0] prod;
  assign prod = NW'(s3_plo_r) + (NW'(s3_phi_r) << DL);

  div_t div_r   [0:CountW];
  div_t div_nxt [0:CountW];

  // one quotient bit per stage
  always_comb begin
    logic [VW:0] trial;
    div_nxt[0]      = '0;
    div_nxt[0].vld  = s3_vld_r;
    div_nxt[0].cls  = s3_cls_r;
    div_nxt[0].st   = s3_st_r;
    div_nxt[0].c    = cnt_r;
    div_nxt[0].w    = s3_w_r;
    div_nxt[0].rem  = prod[NW-1:CountW];   // below w since the quotient fits CountW bits
    div_nxt[0].nlow = prod[CountW-1:0];
    for (int k = 0; k < CountW; k++) begin
      trial = {div_r[k].rem, div_r[k].nlow[CountW-1]};
      div_nxt[k+1]      = div_r[k];
      div_nxt[k+1].nlow = {div_r[k].nlow[CountW-2:0], 1'b0};
      if (trial >= {1'b0, div_r[k].w}) begin
        div_nxt[k+1].rem = VW'(trial - {1'b0, div_r[k].w});
        div_nxt[k+1].q   = {div_r[k].q[CountW-2:0], 1'b1};
      end else begin
        div_nxt[k+1].rem = trial[VW-1:0];
        div_nxt[k+1].q   = {div_r[k].q[CountW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= CountW; k++) begin
      if (!rst_n) div_r[k].vld <= 1'b0;
      else if (adv) div_r[k] <= div_nxt[k];
    end
  end

  // output stage
  div_t            fin;
  logic [CountW:0] idx_full;
  logic [CountW-1:0] idx_nxt;
  status_t         st_nxt;
  logic            out_vld_r;
  logic [CountW-1:0] out_idx_r;
  status_t         out_st_r;

  assign fin = div_r[CountW];

  always_comb begin
    unique case (fin.cls)
      CLS_DIV:   idx_full = {1'b0, fin.q} + (CountW+1)'(1);
      CLS_OVER:  idx_full = {1'b0, fin.c} + (CountW+1)'(1);
      CLS_UNDER: idx_full = '0;
      default:   idx_full = '0;
    endcase
    st_nxt  = fin.st;
    idx_nxt = idx_full[CountW-1:0];
    if (fin.cls == CLS_ERR) begin
      idx_nxt = '0;
    end else if (idx_full > MaxIdx) begin
      idx_nxt = '0;
      st_nxt  = ST_TOO_LARGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= fin.vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r <= idx_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_st_r, out_idx_r};

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && out_st_r != ST_OK |-> out_idx_r == '0)
    else $error("error result with nonzero index");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
      in_tready |=> out_tvalid == $past(fin.vld))
    else $error("pipe did not advance");
`endif

endmodule

// ----- test/width_bucket_integer_chk.sv -----
// ----------------------------------------------------------------------------
// width_bucket_integer_chk
// Watches the sample, result and register channels of the binner, predicts
// each result from its own copy of the bounds and count, compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module width_bucket_integer_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [63:0]                 in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [39:0]                 out_tdata,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [wbi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count
);
  import wbi_pkg::*;

  typedef struct packed {
    logic [30:0] bucket;
    status_t     stat;
  } bin_res_t;

  logic signed [63:0] lo_bound, hi_bound;
  logic [30:0]        n_buckets;
  bin_res_t           bin_q[$];

  function automatic bin_res_t bin_sample(logic signed [63:0] v);
    bin_res_t r;
    logic [127:0] num, den, q;
    logic [32:0] idx;
    r.bucket = '0;
    r.stat = ST_OK;
    idx = '0;
    if (n_buckets == 0) begin
      r.stat = ST_BAD_COUNT;
      return r;
    end
    if (lo_bound == hi_bound) begin
      r.stat = ST_EQ_BOUNDS;
      return r;
    end
    if (lo_bound < hi_bound) begin
      if (v < lo_bound) idx = 0;
      else if (v >= hi_bound) idx = n_buckets + 33'd1;
      else begin
        num = 128'(n_buckets) * 128'($signed(65'(v)) - $signed(65'(lo_bound)));
        den = 128'($signed(65'(hi_bound)) - $signed(65'(lo_bound)));
        q = num / den;
        idx = q[32:0] + 33'd1;
      end
    end else begin
      if (v > lo_bound) idx = 0;
      else if (v <= hi_bound) idx = n_buckets + 33'd1;
      else begin
        num = 128'(n_buckets) * 128'($signed(65'(lo_bound)) - $signed(65'(v)));
        den = 128'($signed(65'(lo_bound)) - $signed(65'(hi_bound)));
        q = num / den;
        idx = q[32:0] + 33'd1;
      end
    end
    if (idx > 33'h7FFF_FFFF) r.stat = ST_TOO_LARGE;
    else r.bucket = idx[30:0];
    return r;
  endfunction

  assign pending = bin_q.size();

  always @(posedge clk) begin
    bin_res_t e, a;
    if (!rst_n) begin
      lo_bound <= 64'sd0;
      hi_bound <= 64'sd100;
      n_buckets <= 31'd1;
      fail_count <= 0;
      result_count <= 0;
      bin_q.delete();
    end else begin
      if (in_tvalid && in_tready) bin_q.push_back(bin_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        a.bucket = out_tdata[30:0];
        a.stat = status_t'(out_tdata[32:31]);
        if (bin_q.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = bin_q.pop_front();
          if (a.bucket !== e.bucket || a.stat !== e.stat) begin
            if (a.bucket !== e.bucket)
              $error("bucket_index expected %0d actual %0d", e.bucket, a.bucket);
            if (a.stat !== e.stat)
              $error("status expected %0d actual %0d", e.stat, a.stat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_BOUND:  lo_bound <= cfg_data;
          REG_SECOND_BOUND: hi_bound <= cfg_data;
          REG_BUCKET_COUNT: n_buckets <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- test/width_bucket_integer_tb.sv -----
// ----------------------------------------------------------------------------
// width_bucket_integer_tb
// Drives samples and register writes into the binner under several bound and
// count settings with random idling on both sides; the checker judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module width_bucket_integer_tb;
  import wbi_pkg::*;

  localparam int Latency = CountW + 6;
  localparam int StallLimit = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count, pending, result_count;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;
  int sent = 0;
  logic signed [63:0] cur_lo, cur_hi;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  width_bucket_integer u_dut (.*);

  width_bucket_integer_chk u_chk (.*);

  // receiver: random backpressure plus an optional long hold
  always @(negedge clk) begin
    out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // called at a falling edge; drops the sample valid first
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic set_bins(logic signed [63:0] lo, logic signed [63:0] hi, logic [30:0] n);
    drain();
    write_reg(REG_FIRST_BOUND, lo);
    write_reg(REG_SECOND_BOUND, hi);
    write_reg(REG_BUCKET_COUNT, {33'd0, n});
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // starts and ends at a falling edge so items can follow back to back
  task automatic send_sample(logic [63:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly values near or between the bounds, some fully random
  function automatic logic [63:0] pick_sample();
    logic signed [63:0] lo, hi, span;
    lo = (cur_lo < cur_hi) ? cur_lo : cur_hi;
    hi = (cur_lo < cur_hi) ? cur_hi : cur_lo;
    case ($urandom_range(5))
      0: return rand64();
      1: return lo + $signed(64'($urandom_range(4))) - 2;
      2: return hi + $signed(64'($urandom_range(4))) - 2;
      default: begin
        span = hi - lo;
        if (span <= 0) return lo;
        return lo + (rand64() % span);
      end
    endcase
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_sample(pick_sample());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, then extremes and each status case
    send_sample(64'sd0);
    send_sample(64'sd99);
    send_sample(64'sd100);
    send_sample(-64'sd1);
    send_sample(64'h8000_0000_0000_0000);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF);
    set_bins(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
    send_sample(64'h8000_0000_0000_0000);
    send_sample(64'h7FFF_FFFF_FFFF_FFFE);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF);
    send_sample(64'd0);
    set_bins(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 31'h7FFF_FFFE);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF);
    send_sample(64'h8000_0000_0000_0001);
    send_sample(64'h8000_0000_0000_0000);
    set_bins(64'sd10, 64'sd10, 31'd5);
    send_sample(64'sd10);
    send_sample(64'sd3);
    set_bins(64'sd10, 64'sd10, 31'd0);
    send_sample(64'sd10);
    set_bins(-64'sd50, 64'sd50, 31'd0);
    send_sample(64'sd0);
    // count+1 too large
    set_bins(64'sd0, 64'sd10, 31'h7FFF_FFFF);
    send_sample(64'sd10);
    send_sample(64'sd9);
    send_sample(-64'sd1);

    // random: receiver idles more, then sender, then none
    send_idle = 36; recv_idle = 58;
    set_bins(-64'sd1000, 64'sd1000, 31'd7);
    random_phase(150);
    set_bins(64'sd500, -64'sd300, 31'd13);
    random_phase(150);
    send_idle = 58; recv_idle = 36;
    set_bins(rand64(), rand64(), 31'($urandom()));
    random_phase(150);
    set_bins(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 31'($urandom_range(1, 100)));
    random_phase(150);

    // long receiver hold while the sender keeps offering
    send_idle = 0; recv_idle = 0;
    set_bins(-64'sd64, 64'sd64, 31'd1);
    fork
      begin
        @(negedge clk) hold_recv = 1'b1;
        repeat (200) @(negedge clk);
        hold_recv = 1'b0;
      end
      random_phase(120);
    join
    set_bins(rand64(), rand64(), 31'h7FFF_FFFF);
    random_phase(100);
    set_bins(64'sd1, 64'sd0, 31'($urandom_range(1, 1000)));
    random_phase(110);

    drain();
    $display("Sent %0d samples, checked %0d results over bucket, bound and status cases.",
             sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/wbi_pkg.sv
hdl/width_bucket_integer.sv
test/width_bucket_integer_chk.sv
test/width_bucket_integer_tb.sv
